// ----- design/bmpfb_pkg.sv -----
// Shared types and constants for the monochrome frame store blitter.
// Holds item codes, result codes, the controller states and the
// command/status structs. No dependencies.
package bmpfb_pkg;

  // Item kinds carried on the request channel.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED  = 2'd1;
  localparam logic [1:0] STATUS_NO_IMAGE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_X_POSITION     = 3'd0;
  localparam logic [2:0] CFG_Y_POSITION     = 3'd1;
  localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_GRAY_THRESHOLD = 3'd4;

  // The gray threshold saturates at this value.
  localparam logic [3:0] THRESH_MAX = 4'd14;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_WR0,
    S_WR1,
    S_ITEM_RD,
    S_CLEAR,
    S_FIN
  } state_t;

  // Frame store operation for the current cycle.
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_RD_PIX0,
    MOP_RD_PIX1,
    MOP_WR_PIX0,
    MOP_WR_PIX1,
    MOP_RD_ITEM,
    MOP_WR_CLEAR
  } mem_op_t;

  typedef struct packed {
    logic    accept;
    logic    finish;
    mem_op_t mop;
  } dp_cmd_t;

  typedef struct packed {
    logic draw_go;
    logic read_ok;
    logic clr_last;
  } dp_status_t;

endpackage

// ----- design/bmpfb_if.sv -----
// Request and result channel interfaces of the frame store blitter.
// Valid/ready handshake with payload; no dependencies.
interface bmpfb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] pixel_byte;
  logic [8:0] read_index;

  modport source (output valid, kind, pixel_byte, read_index, input ready);
  modport sink (input valid, kind, pixel_byte, read_index, output ready);
endinterface

interface bmpfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;
  logic       image_done;

  modport source (output valid, status, read_data, image_done, input ready);
  modport sink (input valid, status, read_data, image_done, output ready);
endinterface

// ----- design/bmpfb_ctrl.sv -----
// Controller state machine of the frame store blitter.
// Uses bmpfb_pkg; drives commands to bmpfb_dp and owns the result valid flag.
module bmpfb_ctrl
  import bmpfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_kind,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '{accept: 1'b0, finish: 1'b0, mop: MOP_NONE};
    unique case (state)
      S_INIT: begin
        cmd.mop = MOP_WR_CLEAR;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          unique case (kind_t'(req_kind))
            KIND_START: state_next = S_FIN;
            KIND_DATA:  state_next = st.draw_go ? S_RD0 : S_FIN;
            KIND_READ:  state_next = st.read_ok ? S_ITEM_RD : S_FIN;
            KIND_CLEAR: state_next = S_CLEAR;
            default:    state_next = S_FIN;
          endcase
        end
      end
      S_RD0: begin
        cmd.mop    = MOP_RD_PIX0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.mop    = MOP_RD_PIX1;
        state_next = S_WR0;
      end
      S_WR0: begin
        cmd.mop    = MOP_WR_PIX0;
        state_next = S_WR1;
      end
      S_WR1: begin
        cmd.mop    = MOP_WR_PIX1;
        state_next = S_FIN;
      end
      S_ITEM_RD: begin
        cmd.mop    = MOP_RD_ITEM;
        state_next = S_FIN;
      end
      S_CLEAR: begin
        cmd.mop = MOP_WR_CLEAR;
        if (st.clr_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp_valid = out_valid;

  // A result is loaded only into a free or draining output register.
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || rsp_ready))
    else $error("result loaded over an untaken result");

  // Each accepted item keeps the block busy, so no item is accepted in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item accepted on consecutive cycles");

  // Leaving reset starts the clearing sweep, so nothing is accepted.
  a_init_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !req_ready)
    else $error("item accepted before the clearing sweep");

endmodule

// ----- design/bmpfb_dp.sv -----
// Datapath of the frame store blitter: configuration registers, image
// cursor state, the single-port frame store and the result register.
// Uses bmpfb_pkg; commanded by bmpfb_ctrl.
module bmpfb_dp
  import bmpfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [1:0] req_kind,
  input  logic [7:0] req_pixel_byte,
  input  logic [8:0] req_read_index,
  output logic [1:0] rsp_status,
  output logic [7:0] rsp_read_data,
  output logic       rsp_image_done,
  input  dp_cmd_t    cmd,
  output dp_status_t st
);

  localparam int STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
  localparam int MEM_AW      = $clog2(STORE_BYTES);
  localparam int SUM_W       = $clog2(STORE_BYTES + 8 * SCREEN_WIDTH + 512);

  // Configuration registers.
  logic [6:0] x_position;
  logic [5:0] y_position;
  logic [7:0] image_width;
  logic [7:0] image_height;
  logic [3:0] gray_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position     <= '0;
      y_position     <= '0;
      image_width    <= '0;
      image_height   <= '0;
      gray_threshold <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_X_POSITION)     x_position     <= cfg_data[6:0];
      if (cfg_index == CFG_Y_POSITION)     y_position     <= cfg_data[5:0];
      if (cfg_index == CFG_IMAGE_WIDTH)    image_width    <= cfg_data;
      if (cfg_index == CFG_IMAGE_HEIGHT)   image_height   <= cfg_data;
      if (cfg_index == CFG_GRAY_THRESHOLD) gray_threshold <= cfg_data[3:0];
    end
  end

  // Image cursor state.
  logic [8:0] column_cursor;
  logic [6:0] bytes_in_row;
  logic [1:0] padding_left;
  logic [2:0] row_bit;
  logic [2:0] page_index;
  logic [7:0] rows_left;
  logic       image_active;
  logic [6:0] row_start;
  logic [6:0] row_len;

  // Latched item.
  kind_t      item_kind;
  logic [7:0] item_pix;
  logic [8:0] item_ridx;
  logic       item_read_ok;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind    <= kind_t'(req_kind);
      item_pix     <= req_pixel_byte;
      item_ridx    <= req_read_index;
      item_read_ok <= st.read_ok;
    end
  end

  logic draw_go;
  logic start_reject;
  logic row_end;
  logic last_byte;
  logic [3:0] thr;

  assign draw_go   = image_active && (padding_left == 2'd0);
  assign row_end   = (bytes_in_row == 7'd1);
  assign last_byte = row_end && (rows_left == 8'd1);
  assign thr       = (gray_threshold > THRESH_MAX) ? THRESH_MAX : gray_threshold;

  assign start_reject = (image_height == 8'd0) || (image_width == 8'd0) ||
                        image_width[0] ||
                        (32'({2'b0, x_position} + {1'b0, image_width}) > SCREEN_WIDTH) ||
                        ({1'b0, y_position} + 7'd1 < {1'b0, image_height[6:0]}) ||
                        image_height[7] ||
                        (32'(y_position) >= SCREEN_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_cursor <= '0;
      bytes_in_row  <= '0;
      padding_left  <= '0;
      row_bit       <= '0;
      page_index    <= '0;
      rows_left     <= '0;
      image_active  <= 1'b0;
      row_start     <= '0;
      row_len       <= '0;
    end else if (cmd.finish) begin
      if (item_kind == KIND_START) begin
        if (start_reject) begin
          image_active <= 1'b0;
        end else begin
          image_active  <= 1'b1;
          row_start     <= x_position;
          row_len       <= image_width[7:1];
          column_cursor <= {2'b0, x_position};
          bytes_in_row  <= image_width[7:1];
          padding_left  <= 2'd0;
          row_bit       <= y_position[2:0];
          page_index    <= y_position[5:3];
          rows_left     <= image_height;
        end
      end else if (item_kind == KIND_DATA && image_active) begin
        if (!draw_go) begin
          padding_left <= padding_left - 2'd1;
        end else if (!row_end) begin
          column_cursor <= column_cursor + 9'd2;
          bytes_in_row  <= bytes_in_row - 7'd1;
        end else begin
          rows_left <= rows_left - 8'd1;
          if (last_byte) begin
            image_active  <= 1'b0;
            column_cursor <= column_cursor + 9'd2;
            bytes_in_row  <= 7'd0;
          end else begin
            if (row_bit != 3'd0) begin
              row_bit <= row_bit - 3'd1;
            end else begin
              row_bit <= 3'd7;
              if (page_index != 3'd0) begin
                page_index <= page_index - 3'd1;
              end
            end
            column_cursor <= {2'b0, row_start};
            bytes_in_row  <= row_len;
            padding_left  <= 2'd0 - row_len[1:0];
          end
        end
      end
    end
  end

  // Frame store addressing.
  logic [SUM_W-1:0]  pix_addr0;
  logic [SUM_W-1:0]  pix_addr1;
  logic              pix_ok0;
  logic              pix_ok1;
  logic [MEM_AW-1:0] clr_cnt;
  logic [SUM_W-1:0]  addr_full;
  logic [MEM_AW-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_q;
  logic [7:0]        hold0;
  logic [7:0]        bit_mask;
  logic              on0;
  logic              on1;

  assign pix_addr0 = SUM_W'(page_index) * SUM_W'(SCREEN_WIDTH) + SUM_W'(column_cursor);
  assign pix_addr1 = pix_addr0 + SUM_W'(1);
  assign pix_ok0   = 32'(pix_addr0) < STORE_BYTES;
  assign pix_ok1   = 32'(pix_addr1) < STORE_BYTES;
  assign bit_mask  = 8'b1 << row_bit;
  assign on0       = item_pix[7:4] > thr;
  assign on1       = item_pix[3:0] > thr;

  always_comb begin
    addr_full = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    unique case (cmd.mop)
      MOP_NONE: begin
      end
      MOP_RD_PIX0: begin
        addr_full = pix_addr0;
        mem_re    = pix_ok0;
      end
      MOP_RD_PIX1: begin
        addr_full = pix_addr1;
        mem_re    = pix_ok1;
      end
      MOP_WR_PIX0: begin
        addr_full = pix_addr0;
        mem_we    = pix_ok0;
        mem_wdata = on0 ? (hold0 | bit_mask) : (hold0 & ~bit_mask);
      end
      MOP_WR_PIX1: begin
        addr_full = pix_addr1;
        mem_we    = pix_ok1;
        mem_wdata = on1 ? (mem_q | bit_mask) : (mem_q & ~bit_mask);
      end
      MOP_RD_ITEM: begin
        addr_full = SUM_W'(item_ridx);
        mem_re    = 1'b1;
      end
      MOP_WR_CLEAR: begin
        addr_full = SUM_W'(clr_cnt);
        mem_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = addr_full[MEM_AW-1:0];

  logic [7:0] store [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= store[mem_addr];
    end
  end

  // The first byte read comes back while the second is being read.
  always_ff @(posedge clk) begin
    if (cmd.mop == MOP_RD_PIX1) begin
      hold0 <= mem_q;
    end
  end

  // Clearing sweep counter; it rests at zero between sweeps.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mop == MOP_WR_CLEAR) begin
      clr_cnt <= st.clr_last ? '0 : clr_cnt + MEM_AW'(1);
    end
  end

  assign st.draw_go  = draw_go;
  assign st.read_ok  = 32'(req_read_index) < STORE_BYTES;
  assign st.clr_last = 32'(clr_cnt) == STORE_BYTES - 1;

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_status     <= STATUS_OK;
      rsp_read_data  <= 8'd0;
      rsp_image_done <= 1'b0;
      unique case (item_kind)
        KIND_START: begin
          if (start_reject) rsp_status <= STATUS_CLIPPED;
        end
        KIND_DATA: begin
          if (!image_active) rsp_status <= STATUS_NO_IMAGE;
          rsp_image_done <= draw_go && last_byte;
        end
        KIND_READ: begin
          if (item_read_ok) rsp_read_data <= mem_q;
        end
        KIND_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_active_has_bytes: assert property (@(posedge clk) disable iff (rst)
    image_active |-> (bytes_in_row != 7'd0))
    else $error("open image with an empty row");

  a_active_has_rows: assert property (@(posedge clk) disable iff (rst)
    image_active |-> (rows_left != 8'd0))
    else $error("open image with no rows left");

  a_cursor_tracks_row: assert property (@(posedge clk) disable iff (rst)
    image_active |-> (32'(column_cursor) + 2 * 32'(bytes_in_row) ==
                      32'(row_start) + 2 * 32'(row_len)))
    else $error("column cursor out of step with bytes left in row");

endmodule

// ----- design/bmp_to_mono_framebuffer_blit.sv -----
// Top level of the 4-bit bitmap to page-packed monochrome frame store blitter.
// Uses bmpfb_pkg, bmpfb_req_if, bmpfb_rsp_if, bmpfb_ctrl and bmpfb_dp.
//
// The block keeps a SCREEN_WIDTH x SCREEN_HEIGHT monochrome frame store, one
// bit per pixel, packed eight rows to a byte (byte page*SCREEN_WIDTH+column,
// bit 0 on top). Every request item returns exactly one result item. A start
// item checks the configured position and size and opens an image; data items
// then carry 4-bit bitmap bytes, two pixels each, bottom row first, with row
// padding bytes skipped. Read items return one store byte, clear items zero
// the store. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while no item is in flight. Sequencing: items are handled
// one at a time by a controller around a single-port frame store with
// registered read data. A start, a padding byte or a data byte with no open
// image goes straight to its result; a read first reads one store byte; a
// data byte that draws reads and rewrites two store bytes through the one
// memory port. A clear writes zero to the whole store, one store byte written
// per cycle, and after reset the same sweep runs before the first item is
// taken; configuration writes are accepted throughout. The result sits in an
// output register, so the block takes the next item while an earlier result
// waits on the result channel.
module bmp_to_mono_framebuffer_blit
  import bmpfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 84,
  parameter int SCREEN_HEIGHT = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  bmpfb_req_if.sink  req,
  bmpfb_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // The controller sequences each item and owns both handshakes.
  bmpfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the image cursor and the frame store.
  bmpfb_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_kind       (req.kind),
    .req_pixel_byte (req.pixel_byte),
    .req_read_index (req.read_index),
    .rsp_status     (rsp.status),
    .rsp_read_data  (rsp.read_data),
    .rsp_image_done (rsp.image_done),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

// ----- verif/bmp_to_mono_framebuffer_blit_tb.sv -----
// Self-checking testbench for the 4-bit bitmap to monochrome frame store blitter.
// Depends on bmpfb_pkg, bmpfb_req_if, bmpfb_rsp_if and the bmp_to_mono_framebuffer_blit
// top level; runs a directed stimulus table, then random image sequences.
module bmp_to_mono_framebuffer_blit_tb;
  import bmpfb_pkg::*;

  localparam int SCREEN_W = 84;
  localparam int SCREEN_H = 48;
  localparam int STORE_BYTES = SCREEN_W * SCREEN_H / 8;
  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 11;
  // A drawing data item is the slowest non-clear item, so this pause covers
  // any write-back still going on after the last result.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 400;
  localparam int REPORT_LIMIT = 10;
  // The slowest legal run (every clear sweeping the store, long stalls on
  // both sides) stays well below this.
  localparam int CYCLE_LIMIT = 400000;

  // One result item as the block returns it.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic       image_done;
  } blit_result_t;

  // One row of the directed stimulus table. A row is either a full set of
  // register writes or one item; typed rows carry their own expected result.
  typedef struct packed {
    logic         is_cfg;
    logic         typed;
    logic [1:0]   kind;
    logic [7:0]   pix;
    logic [8:0]   ridx;
    blit_result_t res;
    logic [7:0]   cx;
    logic [7:0]   cy;
    logic [7:0]   cw;
    logic [7:0]   ch;
    logic [7:0]   ct;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  bmpfb_req_if req_ch ();
  bmpfb_rsp_if rsp_ch ();

  bmp_to_mono_framebuffer_blit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the frame store, the drawing cursor and
  // the configuration registers as the testbench last wrote them.
  // ---------------------------------------------------------------------------
  logic [7:0] mono_store [0:STORE_BYTES-1];
  logic [8:0] col_cur        = '0;
  logic [6:0] row_bytes_left = '0;
  logic [1:0] pad_left       = '0;
  logic [2:0] row_bit        = '0;
  logic [2:0] page           = '0;
  logic [7:0] rows_left      = '0;
  logic       img_open       = 1'b0;
  logic [6:0] start_col      = '0;
  logic [6:0] bytes_per_row  = '0;

  logic [6:0] cfg_x   = '0;
  logic [5:0] cfg_y   = '0;
  logic [7:0] cfg_w   = '0;
  logic [7:0] cfg_h   = '0;
  logic [3:0] cfg_thr = '0;

  // Results still owed by the block, oldest first.
  blit_result_t blit_results_due [$];
  plan_row_t    directed_plan [$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  starts_sent  = 0;
  int  clears_sent  = 0;
  int  phases_run   = 0;
  // While calm is set, neither side idles.
  bit  calm         = 1'b0;

  // Sets or clears one store bit of the current row. Writes past the end of
  // the store are dropped.
  function automatic void paint_pixel(input int col, input logic [3:0] nib,
                                      input logic [3:0] thr);
    int addr;
    addr = int'(page) * SCREEN_W + col;
    if (addr < STORE_BYTES) begin
      if (nib > thr) mono_store[addr][row_bit] = 1'b1;
      else mono_store[addr][row_bit] = 1'b0;
    end
  endfunction

  // Works out the result of one accepted item and advances the private state.
  function automatic blit_result_t blit_predict(input kind_t k, input logic [7:0] pix,
                                                input logic [8:0] ridx);
    blit_result_t res;
    logic [3:0]   thr;
    res = '0;
    case (k)
      KIND_START: begin
        if (cfg_h == 8'd0 || cfg_w == 8'd0 || cfg_w[0] ||
            int'(cfg_x) + int'(cfg_w) > SCREEN_W ||
            int'(cfg_y) + 1 < int'(cfg_h) || int'(cfg_y) >= SCREEN_H) begin
          res.status = STATUS_CLIPPED;
          img_open = 1'b0;
        end else begin
          img_open = 1'b1;
          start_col = cfg_x;
          bytes_per_row = cfg_w[7:1];
          col_cur = 9'(cfg_x);
          row_bytes_left = cfg_w[7:1];
          pad_left = 2'd0;
          row_bit = cfg_y[2:0];
          page = cfg_y[5:3];
          rows_left = cfg_h;
        end
      end
      KIND_DATA: begin
        if (!img_open) begin
          res.status = STATUS_NO_IMAGE;
        end else if (pad_left != 2'd0) begin
          pad_left = pad_left - 2'd1;
        end else begin
          thr = (cfg_thr > THRESH_MAX) ? THRESH_MAX : cfg_thr;
          paint_pixel(int'(col_cur), pix[7:4], thr);
          paint_pixel(int'(col_cur) + 1, pix[3:0], thr);
          col_cur = col_cur + 9'd2;
          row_bytes_left = row_bytes_left - 7'd1;
          if (row_bytes_left == 7'd0) begin
            rows_left = rows_left - 8'd1;
            if (rows_left == 8'd0) begin
              img_open = 1'b0;
              res.image_done = 1'b1;
            end else begin
              // Rows go upward on screen; the page index stops at the top.
              if (row_bit != 3'd0) begin
                row_bit = row_bit - 3'd1;
              end else begin
                row_bit = 3'd7;
                if (page != 3'd0) page = page - 3'd1;
              end
              col_cur = 9'(start_col);
              row_bytes_left = bytes_per_row;
              // Bitmap rows are padded to a multiple of four bytes.
              pad_left = 2'd0 - bytes_per_row[1:0];
            end
          end
        end
      end
      KIND_READ: begin
        if (int'(ridx) < STORE_BYTES) res.read_data = mono_store[ridx];
      end
      default: begin
        foreach (mono_store[i]) mono_store[i] = 8'h00;
      end
    endcase
    return res;
  endfunction

  function automatic plan_row_t item_row(input kind_t k, input logic [7:0] pix,
                                         input logic [8:0] ridx);
    plan_row_t r;
    r = '0;
    r.kind = k;
    r.pix = pix;
    r.ridx = ridx;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input kind_t k, input logic [7:0] pix,
                                          input logic [8:0] ridx, input logic [1:0] st,
                                          input logic [7:0] rd, input logic dn);
    plan_row_t r;
    r = item_row(k, pix, ridx);
    r.typed = 1'b1;
    r.res.status = st;
    r.res.read_data = rd;
    r.res.image_done = dn;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] w, input logic [7:0] h,
                                        input logic [7:0] t);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cx = x;
    r.cy = y;
    r.cw = w;
    r.ch = h;
    r.ct = t;
    return r;
  endfunction

  // Offers one item, with random idle cycles first, and waits for the
  // handshake. Called and left at a falling edge; valid stays high so that a
  // following item can go out back to back.
  task automatic send_item(input kind_t k, input logic [7:0] pix, input logic [8:0] ridx,
                           input bit use_typed, input blit_result_t typed_res);
    blit_result_t pred;
    while (!calm && $urandom_range(99, 0) < 35) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= k;
    req_ch.pixel_byte <= pix;
    req_ch.read_index <= ridx;
    do @(posedge clk); while (!req_ch.ready);
    pred = blit_predict(k, pix, ridx);
    blit_results_due.push_back(use_typed ? typed_res : pred);
    items_sent++;
    if (k == KIND_START) starts_sent++;
    if (k == KIND_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  task automatic send_checked(input kind_t k, input logic [7:0] pix, input logic [8:0] ridx);
    send_item(k, pix, ridx, 1'b0, '0);
  endtask

  // Stops offering items until every owed result has come back, then lets
  // the block finish any store write-back.
  task automatic settle_block();
    req_ch.valid <= 1'b0;
    while (blit_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all five registers, one per cycle, only while the block is idle.
  task automatic set_config(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w,
                            input logic [7:0] h, input logic [7:0] t);
    logic [7:0] vals [5];
    logic [2:0] regs [5];
    vals = '{x, y, w, h, t};
    regs = '{CFG_X_POSITION, CFG_Y_POSITION, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT,
             CFG_GRAY_THRESHOLD};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cfg_x = x[6:0];
    cfg_y = y[5:0];
    cfg_w = w;
    cfg_h = h;
    cfg_thr = t[3:0];
  endtask

  // Picks a legal placement for an image, mostly small, now and then a full
  // screen width, and writes it together with a random threshold.
  task automatic place_image(output int x, output int y, output int w, output int h);
    if ($urandom_range(99, 0) < 5) begin
      w = SCREEN_W;
      x = 0;
      h = $urandom_range(2, 1);
    end else begin
      w = 2 * $urandom_range(8, 1);
      x = $urandom_range(SCREEN_W - w, 0);
      h = $urandom_range(6, 1);
    end
    y = $urandom_range(SCREEN_H - 1, h - 1);
    set_config(8'(x), 8'(y), 8'(w), 8'(h), 8'($urandom_range(15, 0)));
  endtask

  // One random phase: new registers, a start item, then a well-formed stream
  // of bitmap bytes (row padding included) with reads, clears, restarts and
  // truncation mixed in, then a few reads of the area just drawn.
  task automatic random_image_phase();
    int  x, y, w, h, n, pad, done_bytes, r, lo_page;
    bit  noise, rewrite;
    settle_block();
    noise = ($urandom_range(99, 0) < 12);
    if (noise) begin
      set_config(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                 8'($urandom_range(255, 0)));
      n = $urandom_range(12, 1);
    end else begin
      place_image(x, y, w, h);
      pad = (4 - ((w / 2) % 4)) % 4;
      n = (w / 2) * h + pad * (h - 1);
    end
    rewrite = !noise && ($urandom_range(99, 0) < 10);
    send_checked(KIND_START, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
    done_bytes = 0;
    while (done_bytes < n) begin
      // Registers may change while an image is open; position and width
      // only take effect at the next start, the threshold right away.
      if (rewrite && done_bytes == n / 2) begin
        settle_block();
        set_config(8'($urandom_range(127, 0)), 8'($urandom_range(63, 0)),
                   8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                   8'($urandom_range(15, 0)));
        rewrite = 1'b0;
      end
      r = $urandom_range(99, 0);
      if (r < 8) begin
        send_checked(KIND_READ, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
      end else if (r < 10) begin
        send_checked(KIND_CLEAR, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
      end else if (r < 12) begin
        send_checked(KIND_START, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
      end else if (r < 14) begin
        break;
      end else begin
        send_checked(KIND_DATA, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
        done_bytes++;
      end
    end
    // Trailing padding after the last row arrives with no image open, unless cut short.
    if ($urandom_range(99, 0) < 30) begin
      repeat ($urandom_range(3, 1))
        send_checked(KIND_DATA, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
    end
    repeat ($urandom_range(4, 2)) begin
      if (noise) begin
        send_checked(KIND_READ, 8'($urandom_range(255, 0)), 9'($urandom_range(511, 0)));
      end else begin
        lo_page = (y - h + 1) / 8;
        send_checked(KIND_READ, 8'($urandom_range(255, 0)),
                     9'($urandom_range(y / 8, lo_page) * SCREEN_W + x +
                        $urandom_range(w - 1, 0)));
      end
    end
    phases_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and each accepted result is checked against
  // the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99, 0) >= 35);
  end

  always @(posedge clk) begin : check_result
    blit_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (blit_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("[%0t] result item with nothing owed: status=%0d data=%02h done=%0b",
                   $realtime, rsp_ch.status, rsp_ch.read_data, rsp_ch.image_done);
      end else begin
        want = blit_results_due.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.read_data !== want.read_data ||
            rsp_ch.image_done !== want.image_done) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: status %0d/%0d data %02h/%02h done %0b/%0b (exp/act)",
                     $realtime, want.status, rsp_ch.status, want.read_data,
                     rsp_ch.read_data, want.image_done, rsp_ch.image_done);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #(CYCLE_LIMIT * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    foreach (mono_store[i]) mono_store[i] = 8'h00;
    req_ch.valid <= 1'b0;
    req_ch.kind <= KIND_START;
    req_ch.pixel_byte <= 8'h00;
    req_ch.read_index <= 9'd0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_X_POSITION;
    cfg_data <= 8'h00;

    // Directed table. After reset the store is zero and every register is
    // zero, so the first rows have obvious results.
    directed_plan.push_back(typed_row(KIND_READ, 8'h00, 9'd0, STATUS_OK, 8'h00, 1'b0));
    directed_plan.push_back(typed_row(KIND_READ, 8'hFF, 9'd503, STATUS_OK, 8'h00, 1'b0));
    // An address beyond the store reads as zero.
    directed_plan.push_back(typed_row(KIND_READ, 8'h00, 9'd511, STATUS_OK, 8'h00, 1'b0));
    directed_plan.push_back(typed_row(KIND_DATA, 8'hFF, 9'd0, STATUS_NO_IMAGE, 8'h00, 1'b0));
    // Zero width straight out of reset is rejected.
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_CLIPPED, 8'h00, 1'b0));
    // Odd width.
    directed_plan.push_back(cfg_row(8'd0, 8'd47, 8'd3, 8'd1, 8'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_CLIPPED, 8'h00, 1'b0));
    // Runs off the right edge.
    directed_plan.push_back(cfg_row(8'd82, 8'd47, 8'd4, 8'd1, 8'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_CLIPPED, 8'h00, 1'b0));
    // Runs off the top: bottom row 0 with two rows.
    directed_plan.push_back(cfg_row(8'd0, 8'd0, 8'd2, 8'd2, 8'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_CLIPPED, 8'h00, 1'b0));
    // Bottom row just below the screen.
    directed_plan.push_back(cfg_row(8'd0, 8'd48, 8'd2, 8'd1, 8'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_CLIPPED, 8'h00, 1'b0));
    // Zero height.
    directed_plan.push_back(cfg_row(8'd0, 8'd47, 8'd2, 8'd0, 8'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_CLIPPED, 8'h00, 1'b0));
    // A 4x2 image in the bottom right corner; the threshold of 15 saturates
    // at 14, and the two-byte rows carry two padding bytes between them.
    directed_plan.push_back(cfg_row(8'd80, 8'd47, 8'd4, 8'd2, 8'd15));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_OK, 8'h00, 1'b0));
    directed_plan.push_back(item_row(KIND_DATA, 8'hF0, 9'd0));
    directed_plan.push_back(item_row(KIND_DATA, 8'hEF, 9'd0));
    directed_plan.push_back(item_row(KIND_DATA, 8'h00, 9'd0));
    directed_plan.push_back(item_row(KIND_DATA, 8'hFF, 9'd0));
    directed_plan.push_back(item_row(KIND_DATA, 8'h0F, 9'd0));
    directed_plan.push_back(item_row(KIND_DATA, 8'hF0, 9'd0));
    // Padding after the last row is not consumed by the closed image.
    directed_plan.push_back(typed_row(KIND_DATA, 8'hAA, 9'd0, STATUS_NO_IMAGE, 8'h00, 1'b0));
    directed_plan.push_back(item_row(KIND_READ, 8'h00, 9'd500));
    directed_plan.push_back(item_row(KIND_READ, 8'h00, 9'd503));
    // A start while an image is open abandons it; a clear keeps it open.
    directed_plan.push_back(cfg_row(8'd0, 8'd7, 8'd2, 8'd8, 8'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_OK, 8'h00, 1'b0));
    directed_plan.push_back(item_row(KIND_DATA, 8'h11, 9'd0));
    directed_plan.push_back(typed_row(KIND_START, 8'h00, 9'd0, STATUS_OK, 8'h00, 1'b0));
    directed_plan.push_back(typed_row(KIND_CLEAR, 8'h00, 9'd0, STATUS_OK, 8'h00, 1'b0));
    directed_plan.push_back(typed_row(KIND_READ, 8'h00, 9'd0, STATUS_OK, 8'h00, 1'b0));

    // Synchronous reset, released at a falling edge. The block then sweeps
    // its store before it takes the first item; the handshake waits it out.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        settle_block();
        set_config(directed_plan[i].cx, directed_plan[i].cy, directed_plan[i].cw,
                   directed_plan[i].ch, directed_plan[i].ct);
      end else begin
        send_item(kind_t'(directed_plan[i].kind), directed_plan[i].pix,
                  directed_plan[i].ridx, directed_plan[i].typed, directed_plan[i].res);
      end
    end

    // Random part. A stretch in the middle runs with no idling on either side.
    while (items_sent < directed_plan.size() + RANDOM_ITEMS) begin
      calm = (items_sent >= 150 && items_sent < 260);
      random_image_phase();
    end
    calm = 1'b0;

    settle_block();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (blit_results_due.size() != 0) begin
      fail_count++;
      $display("%0d result items never arrived", blit_results_due.size());
    end

    $display("Ran %0d items (%0d starts, %0d clears) over %0d random phases.",
             items_sent, starts_sent, clears_sent, phases_run);
    $display("Checked %0d result items; %0d failures.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bmpfb_pkg.sv
design/bmpfb_if.sv
design/bmpfb_ctrl.sv
design/bmpfb_dp.sv
design/bmp_to_mono_framebuffer_blit.sv
verif/bmp_to_mono_framebuffer_blit_tb.sv
